@@ hdl/slcfc_pkg.sv @@
// Package for the sync / length / CRC-16 frame checker.
// Holds the framing constants, the parser phase type and the CRC byte update.
// No dependencies.
package slcfc_pkg;

	localparam logic [7:0]  SYNC_FIRST  = 8'h5A;
	localparam logic [7:0]  SYNC_SECOND = 8'hA5;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [15:0] PASS_LIMIT  = 16'h8000;

	// Header byte positions after the sync pair
	localparam logic [1:0] HDR_LEN_LO = 2'd0;
	localparam logic [1:0] HDR_LEN_HI = 2'd1;
	localparam logic [1:0] HDR_CRC_LO = 2'd2;
	localparam logic [1:0] HDR_CRC_HI = 2'd3;

	// Parser phase, one-hot
	typedef enum logic [3:0] {
		PH_HUNT    = 4'b0001,
		PH_SYNC2   = 4'b0010,
		PH_HEADER  = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} phase_t;

	// One byte of CRC-16/CCITT, MSB first, no reflection
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ hdl/sync_length_crc16_frame_checker.sv @@
// Top level of the sync / length / CRC-16 frame checker.
// Input byte register, frame parser with running CRC and a result register.
// Depends on slcfc_pkg.
//
// Usage:
//   s_* channel: one received byte per request in s_tdata[7:0].
//   m_* channel: one result per completed frame 5A A5 LENlo LENhi CRClo CRChi
//   payload[LEN]. m_tdata carries the computed CRC, the received CRC and the
//   length; m_tuser carries the pass flag (CRCs equal and length below 32768).
//   Bytes outside a frame and all bytes but the last of a frame give no result.
// Timing:
//   A byte is registered on acceptance and parsed in the next cycle; a frame's
//   result passes from the input register through the parser into the result register.
//   Throughput is one byte per cycle, unless a frame-end byte stalls (see Stall),
//   set by the combinational CRC byte update between the input and result registers.
// Reset:
//   arst_n low clears the parser to hunting for the first sync byte and empties
//   both the input and the result register.
// Stall:
//   While a result waits on m_tready, bytes that end no frame keep flowing;
//   a byte that ends a frame waits in the input register, which then holds
//   s_tready low until the result is taken.
module sync_length_crc16_frame_checker
	import slcfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] crc_computed, [31:16] crc_received,
	                               // [47:32] frame_length
	output logic        m_tuser    // [0] crc_pass
);

	logic        valid_s1;
	logic [7:0]  byte_s1;

	phase_t      phase_q, phase_d;
	logic [1:0]  hdr_cnt_q, hdr_cnt_d;
	logic [15:0] len_q, len_d;
	logic [15:0] remain_q, remain_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] rx_crc_q, rx_crc_d;
	logic        frame_end;

	logic        out_valid_q;
	logic [47:0] out_data_q;
	logic        out_pass_q;

	logic        out_free;
	logic        advance;
	logic        load_out;
	logic [15:0] crc_upd;

	// Handshake decisions
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!frame_end || out_free);
	assign load_out = advance && frame_end;
	assign s_tready = !valid_s1 || advance;

	// Input byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	assign crc_upd = crc_byte(crc_q, byte_s1);

	// Frame parser next state
	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		len_d     = len_q;
		remain_d  = remain_q;
		crc_d     = crc_q;
		rx_crc_d  = rx_crc_q;
		frame_end = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == SYNC_FIRST) begin
					crc_d     = crc_byte(16'h0000, byte_s1);
					hdr_cnt_d = HDR_LEN_LO;
					phase_d   = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				// a wrong second byte is dropped, not re-tested as a first sync
				if (byte_s1 == SYNC_SECOND) begin
					crc_d     = crc_upd;
					hdr_cnt_d = HDR_LEN_LO;
					phase_d   = PH_HEADER;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_HEADER: begin
				case (hdr_cnt_q)
					HDR_LEN_LO: begin
						len_d     = {8'h00, byte_s1};
						crc_d     = crc_upd;
						hdr_cnt_d = HDR_LEN_HI;
					end
					HDR_LEN_HI: begin
						len_d     = {byte_s1, len_q[7:0]};
						crc_d     = crc_upd;
						hdr_cnt_d = HDR_CRC_LO;
					end
					HDR_CRC_LO: begin
						rx_crc_d  = {8'h00, byte_s1};
						hdr_cnt_d = HDR_CRC_HI;
					end
					default: begin
						rx_crc_d  = {byte_s1, rx_crc_q[7:0]};
						hdr_cnt_d = HDR_LEN_LO;
						remain_d  = len_q;
						// zero-length frame ends on the last CRC byte
						if (len_q == 16'h0000) begin
							frame_end = 1'b1;
							phase_d   = PH_HUNT;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				endcase
			end
			default: begin
				crc_d    = crc_upd;
				remain_d = remain_q - 16'd1;
				if (remain_q == 16'd1) begin
					frame_end = 1'b1;
					phase_d   = PH_HUNT;
					hdr_cnt_d = HDR_LEN_LO;
				end
			end
		endcase
	end

	// Parser control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			hdr_cnt_q <= HDR_LEN_LO;
		end else if (advance) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
		end
	end

	// Parser data registers
	always_ff @(posedge clk) begin
		if (advance) begin
			len_q    <= len_d;
			remain_q <= remain_d;
			crc_q    <= crc_d;
			rx_crc_q <= rx_crc_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {len_d, rx_crc_d, crc_d};
			out_pass_q <= (crc_d == rx_crc_d) && (len_d < PASS_LIMIT);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_pass_q;

	// Checks
	a_end_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (phase_q == PH_HUNT))
		else $error("frame end did not return parser to hunting");

	a_pass_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> ((m_tdata[15:0] == m_tdata[31:16]) && !m_tdata[47]))
		else $error("pass flag set on mismatching result");

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (remain_q != 16'h0000))
		else $error("payload phase with nothing remaining");

	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && frame_end && out_valid_q && !m_tready))
		else $error("input stalled without a pending frame end");

endmodule
